// ----- hw/rtl/ugw_pkg.sv -----
// Shared types, constants and code point classes for the UTF-8 cluster width segmenter.
`timescale 1ns / 1ps

package ugw_pkg;

  localparam int CP_W    = 21;
  localparam int LEN_W   = 3;
  localparam int BYTES_W = 8;
  localparam int CW_W    = 2;
  localparam int RW_W    = 16;

  localparam int MAX_CLUSTER_BYTES_DEF = 255;
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // lead byte decoding
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] MASK_E0   = 8'hE0;
  localparam logic [7:0] MASK_F0   = 8'hF0;
  localparam logic [7:0] MASK_F8   = 8'hF8;
  localparam logic [7:0] TAG_2B    = 8'hC0;
  localparam logic [7:0] TAG_3B    = 8'hE0;
  localparam logic [7:0] TAG_4B    = 8'hF0;
  localparam logic [7:0] CONT_MASK = 8'h3F;

  localparam logic [CP_W-1:0] CP_VS16 = 21'h00FE0F;
  localparam logic [CP_W-1:0] CP_VS15 = 21'h00FE0E;

  localparam logic [CW_W-1:0] W_NARROW = 2'd1;
  localparam logic [CW_W-1:0] W_WIDE   = 2'd2;

  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic             fin;
  } token_t;

  typedef struct packed {
    logic [CP_W-1:0]    head;
    logic [BYTES_W-1:0] bytes;
    logic [CW_W-1:0]    width;
    logic [RW_W-1:0]    total;
    logic               last;
  } result_t;

  function automatic logic [CW_W-1:0] wide_of(input logic [CP_W-1:0] c);
    logic w;
    w = (c >= 21'h1100 && c <= 21'h115F) ||
        (c >= 21'h2E80 && c <= 21'hA4CF && c != 21'h303F) ||
        (c >= 21'hAC00 && c <= 21'hD7A3) ||
        (c >= 21'hF900 && c <= 21'hFAFF) ||
        (c >= 21'hFE10 && c <= 21'hFE19) ||
        (c >= 21'hFE30 && c <= 21'hFE6F) ||
        (c >= 21'hFF01 && c <= 21'hFF60) ||
        (c >= 21'hFFE0 && c <= 21'hFFE6) ||
        (c >= 21'h1F300 && c <= 21'h1F9FF);
    return w ? W_WIDE : W_NARROW;
  endfunction

  function automatic logic joins_zero_width(input logic [CP_W-1:0] c);
    return (c >= 21'h200B && c <= 21'h200F) ||
           (c >= 21'hFE00 && c <= 21'hFE0F) ||
           (c >= 21'hE0100 && c <= 21'hE01EF) ||
           (c >= 21'h1F3FB && c <= 21'h1F3FF) ||
           (c >= 21'h0300 && c <= 21'h036F) ||
           (c >= 21'h202A && c <= 21'h202E) ||
           (c >= 21'h2060 && c <= 21'h206F) ||
           (c == 21'hFEFF);
  endfunction

endpackage

// ----- hw/rtl/ugw_queue.sv -----
// Small register queue, one read and up to two writes per cycle; DEPTH must be a power of two (not checked here).
`timescale 1ns / 1ps

module ugw_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   wr_cnt,
  input  logic [W-1:0]                 wr_data0,
  input  logic [W-1:0]                 wr_data1,
  input  logic                         rd_en,
  output logic [W-1:0]                 rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rd_ok;

  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;
  assign rd_data = mem_r[rp_r];
  assign rd_ok   = rd_en && !empty;

  always_comb begin
    wp_nxt  = wp_r + PTR_W'(wr_cnt);
    rp_nxt  = rp_r + PTR_W'(rd_ok);
    cnt_nxt = cnt_r + CNT_W'(wr_cnt) - CNT_W'(rd_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) mem_r[wp_r] <= wr_data0;
    if (wr_cnt == 2'd2) mem_r[wp_r + PTR_W'(1)] <= wr_data1;
  end

endmodule

// ----- hw/rtl/ugw_front.sv -----
// Front end: assembles UTF-8 bytes into code point tokens and tracks end of text.
`timescale 1ns / 1ps

module ugw_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  logic [7:0]     text_byte,
  input  logic           final_byte,
  output logic           tok_valid,
  output ugw_pkg::token_t tok
);

  logic [ugw_pkg::CP_W-1:0]  acc_r, acc_nxt;
  logic [1:0]                left_r, left_nxt;
  logic [ugw_pkg::LEN_W-1:0] dlen_r, dlen_nxt;
  logic                      stopped_r, stopped_nxt;

  always_comb begin
    logic done;
    done        = 1'b0;
    acc_nxt     = acc_r;
    left_nxt    = left_r;
    dlen_nxt    = dlen_r;
    stopped_nxt = stopped_r;
    tok_valid   = 1'b0;
    tok         = '0;
    if (take) begin
      if (!stopped_r) begin
        if (left_r != 2'd0) begin
          acc_nxt  = {acc_r[ugw_pkg::CP_W-7:0], text_byte[5:0]};
          left_nxt = left_r - 2'd1;
          done     = (left_r == 2'd1);
        end else if (text_byte <= ugw_pkg::ASCII_MAX) begin
          acc_nxt  = ugw_pkg::CP_W'(text_byte);
          dlen_nxt = 3'd1;
          done     = 1'b1;
        end else if ((text_byte & ugw_pkg::MASK_E0) == ugw_pkg::TAG_2B) begin
          acc_nxt  = ugw_pkg::CP_W'(text_byte[4:0]);
          dlen_nxt = 3'd2;
          left_nxt = 2'd1;
        end else if ((text_byte & ugw_pkg::MASK_F0) == ugw_pkg::TAG_3B) begin
          acc_nxt  = ugw_pkg::CP_W'(text_byte[3:0]);
          dlen_nxt = 3'd3;
          left_nxt = 2'd2;
        end else if ((text_byte & ugw_pkg::MASK_F8) == ugw_pkg::TAG_4B) begin
          acc_nxt  = ugw_pkg::CP_W'(text_byte[2:0]);
          dlen_nxt = 3'd4;
          left_nxt = 2'd3;
        end else begin
          // bad lead byte stands for itself
          acc_nxt  = ugw_pkg::CP_W'(text_byte);
          dlen_nxt = 3'd1;
          done     = 1'b1;
        end
        if (final_byte) done = 1'b1;
        if (done) begin
          left_nxt  = 2'd0;
          tok_valid = 1'b1;
          tok.cp    = acc_nxt;
          tok.len   = dlen_nxt;
          tok.fin   = final_byte;
          if (acc_nxt == '0) stopped_nxt = 1'b1;
        end
      end
      if (final_byte) begin
        acc_nxt     = '0;
        left_nxt    = 2'd0;
        dlen_nxt    = '0;
        stopped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      left_r    <= 2'd0;
      dlen_r    <= '0;
      stopped_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      left_r    <= left_nxt;
      dlen_r    <= dlen_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// ----- hw/rtl/ugw_back.sv -----
// Back end: groups code points into clusters and emits up to two results per token.
`timescale 1ns / 1ps

module ugw_back #(
  parameter int MAX_CLUSTER_BYTES = ugw_pkg::MAX_CLUSTER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_valid,
  input  ugw_pkg::token_t  tok,
  input  logic             out_room,
  output logic             tok_pop,
  output logic [1:0]       res_cnt,
  output ugw_pkg::result_t res0,
  output ugw_pkg::result_t res1
);

  localparam int BYTES_CAP_I = (MAX_CLUSTER_BYTES < 255) ? MAX_CLUSTER_BYTES : 255;
  localparam logic [ugw_pkg::BYTES_W-1:0] BYTES_CAP = ugw_pkg::BYTES_W'(BYTES_CAP_I);
  localparam logic [ugw_pkg::RW_W-1:0]    TOTAL_MAX = '1;

  logic [ugw_pkg::CP_W-1:0]    head_r, head_nxt;
  logic [ugw_pkg::BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [ugw_pkg::CW_W-1:0]    width_r, width_nxt;
  logic [ugw_pkg::RW_W-1:0]    total_r, total_nxt;
  logic                        open_r, open_nxt;
  logic                        follow_r, follow_nxt;

  function automatic logic [ugw_pkg::BYTES_W-1:0] add_bytes(
    input logic [ugw_pkg::BYTES_W-1:0] b,
    input logic [ugw_pkg::LEN_W-1:0]   l
  );
    logic [ugw_pkg::BYTES_W:0] s;
    s = {1'b0, b} + (ugw_pkg::BYTES_W + 1)'(l);
    return (s > {1'b0, BYTES_CAP}) ? BYTES_CAP : s[ugw_pkg::BYTES_W-1:0];
  endfunction

  function automatic logic [ugw_pkg::RW_W-1:0] add_total(
    input logic [ugw_pkg::RW_W-1:0] t,
    input logic [ugw_pkg::CW_W-1:0] w
  );
    logic [ugw_pkg::RW_W:0] s;
    s = {1'b0, t} + (ugw_pkg::RW_W + 1)'(w);
    return s[ugw_pkg::RW_W] ? TOTAL_MAX : s[ugw_pkg::RW_W-1:0];
  endfunction

  assign tok_pop = tok_valid && out_room;

  always_comb begin
    ugw_pkg::result_t r;
    logic             emit;
    head_nxt   = head_r;
    bytes_nxt  = bytes_r;
    width_nxt  = width_r;
    total_nxt  = total_r;
    open_nxt   = open_r;
    follow_nxt = follow_r;
    res_cnt    = 2'd0;
    res0       = '0;
    res1       = '0;
    r          = '0;
    emit       = 1'b0;
    if (tok_pop) begin
      if (tok.cp == '0) begin
        // end of text: flush the open cluster, then start clean
        if (open_r) begin
          res0.head  = head_r;
          res0.bytes = bytes_r;
          res0.width = width_r;
          res0.total = add_total(total_r, width_r);
          res0.last  = 1'b1;
          res_cnt    = 2'd1;
        end
        head_nxt   = '0;
        bytes_nxt  = '0;
        width_nxt  = '0;
        total_nxt  = '0;
        open_nxt   = 1'b0;
        follow_nxt = 1'b0;
      end else begin
        if (open_r && follow_r && tok.cp == ugw_pkg::CP_VS16 &&
            width_r == ugw_pkg::W_NARROW) begin
          width_nxt  = ugw_pkg::W_WIDE;
          bytes_nxt  = add_bytes(bytes_r, tok.len);
          follow_nxt = 1'b0;
        end else if (open_r && follow_r && tok.cp == ugw_pkg::CP_VS15 &&
                     width_r == ugw_pkg::W_WIDE) begin
          width_nxt  = ugw_pkg::W_NARROW;
          bytes_nxt  = add_bytes(bytes_r, tok.len);
          follow_nxt = 1'b0;
        end else if (open_r && ugw_pkg::joins_zero_width(tok.cp)) begin
          bytes_nxt  = add_bytes(bytes_r, tok.len);
          follow_nxt = 1'b0;
        end else begin
          if (open_r) begin
            emit      = 1'b1;
            r.head    = head_r;
            r.bytes   = bytes_r;
            r.width   = width_r;
            r.total   = add_total(total_r, width_r);
            r.last    = 1'b0;
            total_nxt = r.total;
          end
          head_nxt   = tok.cp;
          bytes_nxt  = add_bytes('0, tok.len);
          width_nxt  = ugw_pkg::wide_of(tok.cp);
          open_nxt   = 1'b1;
          follow_nxt = 1'b1;
        end
        res0    = r;
        res_cnt = {1'b0, emit};
        if (tok.fin) begin
          // last byte closes the cluster just built
          if (emit) begin
            res1.head  = head_nxt;
            res1.bytes = bytes_nxt;
            res1.width = width_nxt;
            res1.total = add_total(total_nxt, width_nxt);
            res1.last  = 1'b1;
            res_cnt    = 2'd2;
          end else begin
            res0.head  = head_nxt;
            res0.bytes = bytes_nxt;
            res0.width = width_nxt;
            res0.total = add_total(total_nxt, width_nxt);
            res0.last  = 1'b1;
            res_cnt    = 2'd1;
          end
          head_nxt   = '0;
          bytes_nxt  = '0;
          width_nxt  = '0;
          total_nxt  = '0;
          open_nxt   = 1'b0;
          follow_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      bytes_r  <= '0;
      width_r  <= '0;
      total_r  <= '0;
      open_r   <= 1'b0;
      follow_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      bytes_r  <= bytes_nxt;
      width_r  <= width_nxt;
      total_r  <= total_nxt;
      open_r   <= open_nxt;
      follow_r <= follow_nxt;
    end
  end

endmodule

// ----- hw/rtl/utf8_grapheme_width_segmenter.sv -----
// Top level of the UTF-8 cluster width segmenter.
//
// Input channel: one text byte per item on in_text_byte, with in_final_byte
// marking the last byte of a text. An item is taken on a clock edge with
// in_push high and in_full low.
// Result channel: one closed cluster per item (head code point, byte count,
// cell width, running width, last flag). The oldest result sits on the out_
// ports while out_empty is low and leaves on an edge with out_pop high.
// Throughput: one byte per cycle while in_full is low. For a byte that closes
// a cluster, the front decode writes its token into the token queue at the
// edge that takes it, and the back cluster stage then writes the result
// into the result queue; a final byte may give two results.
// The back stage retires one token a cycle while the four-entry result
// queue has room for two results; when the receiver stalls, the result
// queue fills, the back stage holds, the two-entry token queue fills and
// in_full rises. No result is dropped.
// Reset (rst_n low, synchronous) empties both queues and clears all decode
// and cluster state, so the next byte starts a new text.
`timescale 1ns / 1ps

module utf8_grapheme_width_segmenter #(
  parameter int MAX_CLUSTER_BYTES = ugw_pkg::MAX_CLUSTER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [7:0]                     in_text_byte,
  input  logic                           in_final_byte,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [ugw_pkg::CP_W-1:0]       out_head_code_point,
  output logic [ugw_pkg::BYTES_W-1:0]    out_cluster_bytes,
  output logic [ugw_pkg::CW_W-1:0]       out_cell_width,
  output logic [ugw_pkg::RW_W-1:0]       out_running_width,
  output logic                           out_last_cluster
);

  localparam int TOK_W     = $bits(ugw_pkg::token_t);
  localparam int RES_W     = $bits(ugw_pkg::result_t);
  localparam int MID_CNT_W = $clog2(ugw_pkg::MID_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(ugw_pkg::OUT_DEPTH + 1);

  logic                 take;
  logic                 tok_valid, mid_empty, tok_pop;
  logic [MID_CNT_W-1:0] mid_level;
  ugw_pkg::token_t      tok_in, tok_out;
  logic [1:0]           res_cnt;
  ugw_pkg::result_t     res0, res1, res_head;
  logic [OUT_CNT_W-1:0] out_level;
  logic                 out_room2;

  assign take      = in_push && !in_full;
  assign in_full   = (mid_level == MID_CNT_W'(ugw_pkg::MID_DEPTH));
  assign out_room2 = (out_level <= OUT_CNT_W'(ugw_pkg::OUT_DEPTH - 2));

  ugw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .text_byte  (in_text_byte),
    .final_byte (in_final_byte),
    .tok_valid  (tok_valid),
    .tok        (tok_in)
  );

  ugw_queue #(
    .W     (TOK_W),
    .DEPTH (ugw_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   ({1'b0, tok_valid}),
    .wr_data0 (tok_in),
    .wr_data1 ('0),
    .rd_en    (tok_pop),
    .rd_data  (tok_out),
    .empty    (mid_empty),
    .level    (mid_level)
  );

  ugw_back #(
    .MAX_CLUSTER_BYTES (MAX_CLUSTER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (!mid_empty),
    .tok       (tok_out),
    .out_room  (out_room2),
    .tok_pop   (tok_pop),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  ugw_queue #(
    .W     (RES_W),
    .DEPTH (ugw_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (res_cnt),
    .wr_data0 (res0),
    .wr_data1 (res1),
    .rd_en    (out_pop),
    .rd_data  (res_head),
    .empty    (out_empty),
    .level    (out_level)
  );

  assign out_head_code_point = res_head.head;
  assign out_cluster_bytes   = res_head.bytes;
  assign out_cell_width      = res_head.width;
  assign out_running_width   = res_head.total;
  assign out_last_cluster    = res_head.last;

endmodule

// ----- hw/rtl/ugw_checker.sv -----
// Port-level checker for the segmenter, bound to the top level.
`timescale 1ns / 1ps

module ugw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_full,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic [ugw_pkg::CP_W-1:0]    out_head_code_point,
  input logic [ugw_pkg::BYTES_W-1:0] out_cluster_bytes,
  input logic [ugw_pkg::CW_W-1:0]    out_cell_width,
  input logic [ugw_pkg::RW_W-1:0]    out_running_width,
  input logic                        out_last_cluster
);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_width_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_cell_width == ugw_pkg::W_NARROW ||
                    out_cell_width == ugw_pkg::W_WIDE))
    else $error("cell width out of range");

  a_total_covers_width: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_cluster_bytes != '0 &&
                    out_running_width >= ugw_pkg::RW_W'(out_cell_width)))
    else $error("empty cluster or running width below cell width");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_head_code_point) &&
                                  $stable(out_running_width) &&
                                  $stable(out_last_cluster)))
    else $error("stalled result changed");

endmodule

bind utf8_grapheme_width_segmenter ugw_checker u_ugw_checker (.*);
